FILE: src/tpsq_pkg.sv
// ----------------------------------------------------------------------------
// Two-class priority service queue package
// Shared payload types, command struct, field codes and default sizes.
// ----------------------------------------------------------------------------
package tpsq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

   // Width and reset value of the queue limit register.
   localparam int unsigned     LIMIT_W     = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // Item kinds.
   localparam logic [1:0] KIND_LAND_REQ    = 2'd0;
   localparam logic [1:0] KIND_TAKEOFF_REQ = 2'd1;
   localparam logic [1:0] KIND_TICK        = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
   localparam logic [2:0] STATUS_REFUSED  = 3'd1;
   localparam logic [2:0] STATUS_LANDED   = 3'd2;
   localparam logic [2:0] STATUS_TOOK_OFF = 3'd3;
   localparam logic [2:0] STATUS_IDLE     = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] served_arrival;
      logic [31:0] wait_res;
      logic [31:0] land_requests;
      logic [31:0] takeoff_requests;
      logic [31:0] land_refused;
      logic [31:0] takeoff_refused;
      logic [31:0] landings;
      logic [31:0] takeoffs;
      logic [47:0] land_wait_total;
      logic [47:0] takeoff_wait_total;
      logic [31:0] idle_ticks;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the item and read both queue heads
      logic exec;   // update queues and counters, issue the result
   } cmd_type;

endpackage

FILE: src/tpsq_ctrl.sv
// ----------------------------------------------------------------------------
// Two-class priority service queue controller
// Two-state sequencer that accepts an item and then runs the execute state.
// ----------------------------------------------------------------------------
module tpsq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output tpsq_pkg::cmd_type cmd
);
   import tpsq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy     = busy_ff;
   assign cmd.load = start & ~busy_ff;
   assign cmd.exec = (state_ff == ST_EXEC);

endmodule

FILE: src/tpsq_datapath.sv
// ----------------------------------------------------------------------------
// Two-class priority service queue datapath
// Queue storage, pointers, event counters, wait totals and result register.
// ----------------------------------------------------------------------------
module tpsq_datapath #(
   parameter int unsigned QUEUE_DEPTH = tpsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tpsq_pkg::cmd_type              cmd,
   input  tpsq_pkg::req_type              req_data,
   input  logic                           csr_write_en,
   input  logic [tpsq_pkg::LIMIT_W-1:0]   csr_write_data,
   output logic                           rsp_valid,
   output tpsq_pkg::rsp_type              rsp_data
);
   import tpsq_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int unsigned SUM_W = CNT_W + 1;
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   // Slot just past the newest entry, wrapped into the ring.
   function automatic logic [PTR_W-1:0] tail_addr(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(count);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
   endfunction

   logic [31:0] land_mem [QUEUE_DEPTH];
   logic [31:0] take_mem [QUEUE_DEPTH];

   req_type            item_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [31:0]        land_rd_ff, take_rd_ff;

   logic [PTR_W-1:0] land_head_ff, land_head_in, take_head_ff, take_head_in;
   logic [CNT_W-1:0] land_count_ff, land_count_in, take_count_ff, take_count_in;

   logic [31:0] land_req_ff, land_req_in, take_req_ff, take_req_in;
   logic [31:0] land_ref_ff, land_ref_in, take_ref_ff, take_ref_in;
   logic [31:0] landings_ff, landings_in, takeoffs_ff, takeoffs_in;
   logic [31:0] idle_ff, idle_in;
   logic [47:0] land_total_ff, land_total_in, take_total_ff, take_total_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0] limit_ext, eff_limit;
   logic             land_full, take_full, land_push, take_push;
   logic [2:0]       status;
   logic [31:0]      arrival, wait_val;

   assign limit_ext = CMP_W'(limit_ff);
   assign eff_limit = (limit_ext > DEPTH_CMP) ? DEPTH_CMP : limit_ext;
   assign land_full = CMP_W'(land_count_ff) >= eff_limit;
   assign take_full = CMP_W'(take_count_ff) >= eff_limit;

   always_comb begin
      land_head_in  = land_head_ff;
      land_count_in = land_count_ff;
      take_head_in  = take_head_ff;
      take_count_in = take_count_ff;
      land_req_in   = land_req_ff;
      take_req_in   = take_req_ff;
      land_ref_in   = land_ref_ff;
      take_ref_in   = take_ref_ff;
      landings_in   = landings_ff;
      takeoffs_in   = takeoffs_ff;
      idle_in       = idle_ff;
      land_total_in = land_total_ff;
      take_total_in = take_total_ff;
      land_push     = 1'b0;
      take_push     = 1'b0;
      status        = STATUS_ACCEPTED;
      arrival       = '0;
      wait_val      = '0;
      rsp_valid_in  = 1'b0;
      if (cmd.exec) begin
         case (item_ff.kind)
            KIND_LAND_REQ: begin
               rsp_valid_in = 1'b1;
               land_req_in  = land_req_ff + 32'd1;
               if (land_full) begin
                  land_ref_in = land_ref_ff + 32'd1;
                  status      = STATUS_REFUSED;
               end else begin
                  land_push     = 1'b1;
                  land_count_in = land_count_ff + 1'b1;
               end
            end
            KIND_TAKEOFF_REQ: begin
               rsp_valid_in = 1'b1;
               take_req_in  = take_req_ff + 32'd1;
               if (take_full) begin
                  take_ref_in = take_ref_ff + 32'd1;
                  status      = STATUS_REFUSED;
               end else begin
                  take_push     = 1'b1;
                  take_count_in = take_count_ff + 1'b1;
               end
            end
            KIND_TICK: begin
               rsp_valid_in = 1'b1;
               if (land_count_ff != '0) begin
                  arrival       = land_rd_ff;
                  wait_val      = item_ff.time_stamp - land_rd_ff;
                  land_total_in = land_total_ff + 48'(wait_val);
                  land_head_in  = next_ptr(land_head_ff);
                  land_count_in = land_count_ff - 1'b1;
                  landings_in   = landings_ff + 32'd1;
                  status        = STATUS_LANDED;
               end else if (take_count_ff != '0) begin
                  arrival       = take_rd_ff;
                  wait_val      = item_ff.time_stamp - take_rd_ff;
                  take_total_in = take_total_ff + 48'(wait_val);
                  take_head_in  = next_ptr(take_head_ff);
                  take_count_in = take_count_ff - 1'b1;
                  takeoffs_in   = takeoffs_ff + 32'd1;
                  status        = STATUS_TOOK_OFF;
               end else begin
                  idle_in = idle_ff + 32'd1;
                  status  = STATUS_IDLE;
               end
            end
            default: begin
               // The unused kind leaves everything as it is.
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.status             = status;
      rsp_data_in.served_arrival     = arrival;
      rsp_data_in.wait_res           = wait_val;
      rsp_data_in.land_requests      = land_req_in;
      rsp_data_in.takeoff_requests   = take_req_in;
      rsp_data_in.land_refused       = land_ref_in;
      rsp_data_in.takeoff_refused    = take_ref_in;
      rsp_data_in.landings           = landings_in;
      rsp_data_in.takeoffs           = takeoffs_in;
      rsp_data_in.land_wait_total    = land_total_in;
      rsp_data_in.takeoff_wait_total = take_total_in;
      rsp_data_in.idle_ticks         = idle_in;
   end

   // Landing queue storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (land_push) begin
         land_mem[tail_addr(land_head_ff, land_count_ff)] <= item_ff.time_stamp;
      end
      if (cmd.load) begin
         land_rd_ff <= land_mem[land_head_ff];
      end
   end

   // Takeoff queue storage.
   always_ff @(posedge clock) begin
      if (take_push) begin
         take_mem[tail_addr(take_head_ff, take_count_ff)] <= item_ff.time_stamp;
      end
      if (cmd.load) begin
         take_rd_ff <= take_mem[take_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         land_head_ff  <= '0;
         land_count_ff <= '0;
         take_head_ff  <= '0;
         take_count_ff <= '0;
         land_req_ff   <= '0;
         take_req_ff   <= '0;
         land_ref_ff   <= '0;
         take_ref_ff   <= '0;
         landings_ff   <= '0;
         takeoffs_ff   <= '0;
         idle_ff       <= '0;
         land_total_ff <= '0;
         take_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         land_head_ff  <= land_head_in;
         land_count_ff <= land_count_in;
         take_head_ff  <= take_head_in;
         take_count_ff <= take_count_in;
         land_req_ff   <= land_req_in;
         take_req_ff   <= take_req_in;
         land_ref_ff   <= land_ref_in;
         take_ref_ff   <= take_ref_in;
         landings_ff   <= landings_in;
         takeoffs_ff   <= takeoffs_in;
         idle_ff       <= idle_in;
         land_total_ff <= land_total_in;
         take_total_ff <= take_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/two_class_priority_service_queue_core.sv
// ----------------------------------------------------------------------------
// Two-class priority service queue core
// Landing and takeoff request queues served by priority on service ticks.
// ----------------------------------------------------------------------------
// Usage: a request or tick is transferred at a rising clock edge at which
// start is high and busy is low; req_data carries the kind and time stamp.
// Landing and takeoff requests are admitted into their own ring queue while
// it holds fewer entries than the smaller of the queue limit and the queue
// depth, and are refused otherwise. A tick serves the landing head first,
// then the takeoff head, and otherwise counts an idle tick.
// Each item of a valid kind yields one result, shown on rsp_data for exactly
// one cycle with rsp_valid high. It is registered at the end of the execute
// state. The receiver cannot stall the block, so a result must be taken when
// shown. Busy stays high for one cycle after each transfer while the queue
// heads, read from registered queue memories at the accepting edge, are
// consumed and all counters update. A new item can therefore be transferred
// only after the execute state ends, a constraint set by the registered read
// of the queue memories. The unused kind produces no result and changes nothing.
// The user is to write the queue limit register through csr_write_en and
// csr_write_data only while the block is idle; the block itself does not
// enforce this. Synchronous reset empties both queues, clears all counters
// and totals and sets the limit to sixteen.
// ----------------------------------------------------------------------------
module two_class_priority_service_queue_core #(
   parameter int unsigned QUEUE_DEPTH = tpsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tpsq_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output tpsq_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_en,
   input  logic [tpsq_pkg::LIMIT_W-1:0]   csr_write_data
);
   import tpsq_pkg::*;

   cmd_type cmd;

   // The controller sequences each transfer through the execute state.
   tpsq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds both queues, every counter and the result register.
   tpsq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

   // A transfer always makes the block busy on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a transfer");

   // The execute phase lasts exactly one cycle.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   // A result only follows an execute cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result shown without a preceding execute cycle");

   // Results are single-cycle strobes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

FILE: tb/two_class_priority_service_queue_core_test.sv
// ----------------------------------------------------------------------------
// Two-class priority service queue core testbench
// Drives landing requests, takeoff requests and service ticks through the
// start/busy handshake. Each transfer goes through a cycle-free model of the
// two runway queues and their counters. Every result strobe is then checked
// field by field against the oldest expected result. A directed table comes
// first, then random phases that run under several queue limits and idle
// patterns.
// ----------------------------------------------------------------------------
module two_class_priority_service_queue_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import tpsq_pkg::*;

   localparam int unsigned DEPTH        = QUEUE_DEPTH_DEFAULT;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 225;
   // Cycles to let pass once nothing is expected. The result is registered
   // after its execute state, and an unused kind may still be in flight.
   localparam int          SETTLE_CYCLES = 4;
   localparam int          DRAIN_LIMIT   = 500;

   // The package names the three real kinds. The fourth code is unused.
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_op_type;

   // One row of the directed table. It is either an item or a write of the
   // queue limit. A row may carry the result typed in by hand.
   typedef struct {
      row_op_type       op;
      req_type          item;
      bit               typed;
      rsp_type          want;
      logic [LIMIT_W-1:0] limit;
   } row_type;

   // -------------------------------------------------------------------------
   // Block inputs. All of them are known from time zero.
   // -------------------------------------------------------------------------
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   req_type            req_data       = '0;
   logic               csr_write_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_write_data = '0;
   logic               busy;
   logic               rsp_valid;
   rsp_type            rsp_data;

   // A directed row with a typed-in result travels beside req_data. The
   // monitor then queues the typed value in place of the prediction.
   logic               typed_row      = 1'b0;
   rsp_type            typed_want     = '0;

   two_class_priority_service_queue_core #(
      .QUEUE_DEPTH (DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // -------------------------------------------------------------------------
   // Runway model. It keeps its own copy of both queues, the limit and every
   // counter. The counters live in an rsp_type, so a result is a copy of
   // them with the per-item fields filled in.
   // -------------------------------------------------------------------------
   logic [31:0]        land_queue[$];
   logic [31:0]        takeoff_queue[$];
   logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;
   rsp_type            tally       = '0;
   rsp_type            pending_results[$];

   // Figures for the closing summary.
   int unsigned        items_accepted   = 0;
   int unsigned        results_checked  = 0;
   int unsigned        status_seen[5]   = '{default: 0};
   int unsigned        deepest_queue    = 0;
   int unsigned        limits_written   = 0;
   int unsigned        fail_count       = 0;

   // Applies one item to the model. It returns 0 for the unused kind, which
   // leaves everything as it was.
   function automatic bit runway_predict(input req_type item, output rsp_type res);
      logic [31:0] arrival;
      logic [31:0] waited;
      logic [2:0]  status;
      int unsigned cap;
      arrival = '0;
      waited  = '0;
      status  = STATUS_ACCEPTED;
      res     = '0;
      // A limit above the storage depth saturates at the depth.
      cap = (limit_model > DEPTH) ? DEPTH : limit_model;
      case (item.kind)
         KIND_LAND_REQ: begin
            tally.land_requests += 32'd1;
            if (land_queue.size() < cap) begin
               land_queue.push_back(item.time_stamp);
            end else begin
               tally.land_refused += 32'd1;
               status = STATUS_REFUSED;
            end
         end
         KIND_TAKEOFF_REQ: begin
            tally.takeoff_requests += 32'd1;
            if (takeoff_queue.size() < cap) begin
               takeoff_queue.push_back(item.time_stamp);
            end else begin
               tally.takeoff_refused += 32'd1;
               status = STATUS_REFUSED;
            end
         end
         KIND_TICK: begin
            // Landings always go first. A takeoff is served only when no
            // landing is waiting.
            if (land_queue.size() != 0) begin
               arrival = land_queue.pop_front();
               waited  = item.time_stamp - arrival;
               tally.land_wait_total += {16'd0, waited};
               tally.landings += 32'd1;
               status = STATUS_LANDED;
            end else if (takeoff_queue.size() != 0) begin
               arrival = takeoff_queue.pop_front();
               waited  = item.time_stamp - arrival;
               tally.takeoff_wait_total += {16'd0, waited};
               tally.takeoffs += 32'd1;
               status = STATUS_TOOK_OFF;
            end else begin
               tally.idle_ticks += 32'd1;
               status = STATUS_IDLE;
            end
         end
         default: begin
            return 1'b0;
         end
      endcase
      res                = tally;
      res.status         = status;
      res.served_arrival = arrival;
      res.wait_res       = waited;
      return 1'b1;
   endfunction

   // Builds a full result by hand for the typed-in directed rows.
   function automatic rsp_type make_result(
      logic [2:0] status, logic [31:0] arrival, logic [31:0] waited,
      logic [31:0] lreq, logic [31:0] treq, logic [31:0] lref, logic [31:0] tref,
      logic [31:0] lands, logic [31:0] takes, logic [47:0] lwt, logic [47:0] twt,
      logic [31:0] idles);
      rsp_type r;
      r.status             = status;
      r.served_arrival     = arrival;
      r.wait_res           = waited;
      r.land_requests      = lreq;
      r.takeoff_requests   = treq;
      r.land_refused       = lref;
      r.takeoff_refused    = tref;
      r.landings           = lands;
      r.takeoffs           = takes;
      r.land_wait_total    = lwt;
      r.takeoff_wait_total = twt;
      r.idle_ticks         = idles;
      return r;
   endfunction

   // Compares one field and reports it when it differs. X or Z is a mismatch.
   function automatic int field_check(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // -------------------------------------------------------------------------
   // Monitor. It samples at the rising edge. Every block input is driven
   // with nonblocking assignments at that same edge, so the values seen
   // here are the ones that stood during the cycle that just ended.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      int      bad;
      if (reset) begin
         land_queue.delete();
         takeoff_queue.delete();
         pending_results.delete();
         tally       = '0;
         limit_model = LIMIT_RESET;
      end else begin
         if (csr_write_en) begin
            limit_model = csr_write_data;
         end
         // A transfer takes place at an edge where start is high and busy
         // is low.
         if (start && !busy) begin
            items_accepted++;
            if (runway_predict(req_data, predicted)) begin
               pending_results.push_back(typed_row ? typed_want : predicted);
               if (predicted.status <= STATUS_IDLE) begin
                  status_seen[predicted.status]++;
               end
            end
            if (land_queue.size() > deepest_queue) begin
               deepest_queue = land_queue.size();
            end
            if (takeoff_queue.size() > deepest_queue) begin
               deepest_queue = takeoff_queue.size();
            end
         end
         // A result strobe lasts exactly one cycle, so each strobe is one
         // result.
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result with status %0d arrived with nothing expected",
                      rsp_data.status);
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               results_checked++;
               bad = 0;
               bad += field_check("status", 48'(oldest.status), 48'(rsp_data.status));
               bad += field_check("served_arrival", 48'(oldest.served_arrival),
                                  48'(rsp_data.served_arrival));
               bad += field_check("wait_res", 48'(oldest.wait_res),
                                  48'(rsp_data.wait_res));
               bad += field_check("land_requests", 48'(oldest.land_requests),
                                  48'(rsp_data.land_requests));
               bad += field_check("takeoff_requests", 48'(oldest.takeoff_requests),
                                  48'(rsp_data.takeoff_requests));
               bad += field_check("land_refused", 48'(oldest.land_refused),
                                  48'(rsp_data.land_refused));
               bad += field_check("takeoff_refused", 48'(oldest.takeoff_refused),
                                  48'(rsp_data.takeoff_refused));
               bad += field_check("landings", 48'(oldest.landings),
                                  48'(rsp_data.landings));
               bad += field_check("takeoffs", 48'(oldest.takeoffs),
                                  48'(rsp_data.takeoffs));
               bad += field_check("land_wait_total", oldest.land_wait_total,
                                  rsp_data.land_wait_total);
               bad += field_check("takeoff_wait_total", oldest.takeoff_wait_total,
                                  rsp_data.takeoff_wait_total);
               bad += field_check("idle_ticks", 48'(oldest.idle_ticks),
                                  48'(rsp_data.idle_ticks));
               if (bad != 0) begin
                  fail_count++;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver side.
   // -------------------------------------------------------------------------
   row_type     directed_rows[$];
   int unsigned no_idle_left = 0;

   task automatic add_item(logic [1:0] kind, logic [31:0] stamp);
      row_type r;
      r.op         = ROW_ITEM;
      r.item.kind  = kind;
      r.item.time_stamp = stamp;
      r.typed      = 1'b0;
      r.want       = '0;
      r.limit      = '0;
      directed_rows.push_back(r);
   endtask

   task automatic add_typed(logic [1:0] kind, logic [31:0] stamp, rsp_type want);
      add_item(kind, stamp);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].want  = want;
   endtask

   task automatic add_limit(logic [LIMIT_W-1:0] value);
      row_type r;
      r.op    = ROW_LIMIT;
      r.item  = '0;
      r.typed = 1'b0;
      r.want  = '0;
      r.limit = value;
      directed_rows.push_back(r);
   endtask

   // Idle cycles before the next item. The count is geometric in the idle
   // share. Now and then a burst of back-to-back items is forced, so that
   // even the idling phases have stretches with no gaps.
   function automatic int pick_gap(int idle_pct);
      int g;
      g = 0;
      if (idle_pct == 0) begin
         return 0;
      end
      if (no_idle_left != 0) begin
         no_idle_left--;
         return 0;
      end
      if ($urandom_range(99) < 4) begin
         no_idle_left = $urandom_range(30, 10);
         return 0;
      end
      while (g < 20 && $urandom_range(99) < idle_pct) begin
         g++;
      end
      return g;
   endfunction

   // Presents one item and waits for its transfer. Start is left high
   // afterwards. The next call replaces the item in the same time step, or
   // it lowers start for a gap, so start gets only one assignment per step.
   task automatic send_item(req_type item, bit typed, rsp_type want, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_data   <= item;
      typed_row  <= typed;
      typed_want <= want;
      do @(posedge clock); while (busy);
   endtask

   // Waits until every expected result has arrived, then lets the block
   // settle. An unused kind may still be in flight.
   task automatic wait_settled();
      for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the queue limit while the block is idle.
   task automatic set_limit(logic [LIMIT_W-1:0] value);
      start <= 1'b0;
      wait_settled();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      limits_written++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase_limit[PHASES];
      int          phase_idle[PHASES];
      logic [31:0] clock_now;
      req_type     item;
      int          req_pct;
      int          land_share;
      int          roll;
      int          n;
      logic [LIMIT_W-1:0] lim;

      phase_limit = '{16, 31, 0, 1, 17, 2, 99, 16};
      phase_idle  = '{0, 56, 11, 56, 0, 11, 56, 0};

      // Directed part. The first rows start from reset, and their results
      // are typed in. They cover an idle tick, then a landing whose wait of
      // FFFF_FFFA lies near the top of the range. A takeoff follows whose wait wraps
      // through zero.
      add_typed(KIND_TICK, 32'h0000_0000,
                make_result(STATUS_IDLE, 0, 0, 0, 0, 0, 0, 0, 0, 48'd0, 48'd0, 1));
      add_typed(KIND_LAND_REQ, 32'h0000_0005,
                make_result(STATUS_ACCEPTED, 0, 0, 1, 0, 0, 0, 0, 0, 48'd0, 48'd0, 1));
      add_typed(KIND_TICK, 32'hFFFF_FFFF,
                make_result(STATUS_LANDED, 32'h5, 32'hFFFF_FFFA, 1, 0, 0, 0, 1, 0,
                            48'hFFFF_FFFA, 48'd0, 1));
      add_typed(KIND_TAKEOFF_REQ, 32'hFFFF_FFFF,
                make_result(STATUS_ACCEPTED, 0, 0, 1, 1, 0, 0, 1, 0,
                            48'hFFFF_FFFA, 48'd0, 1));
      add_typed(KIND_TICK, 32'h0000_0000,
                make_result(STATUS_TOOK_OFF, 32'hFFFF_FFFF, 32'h1, 1, 1, 0, 0, 1, 1,
                            48'hFFFF_FFFA, 48'h1, 1));
      // The unused kind yields nothing and changes nothing.
      add_item(KIND_UNUSED, 32'hAAAA_5555);
      // Both classes are waiting, so the landing is served first.
      add_item(KIND_LAND_REQ, 32'h0000_0001);
      add_item(KIND_TAKEOFF_REQ, 32'h0000_0002);
      add_item(KIND_TICK, 32'h0000_0003);
      add_item(KIND_TICK, 32'h0000_0004);
      // With a limit of zero, every request of both classes is refused.
      add_limit(5'd0);
      add_item(KIND_LAND_REQ, 32'h5555_AAAA);
      add_item(KIND_TAKEOFF_REQ, 32'h0000_0000);
      add_item(KIND_TICK, 32'hFFFF_FFFF);
      // With a limit of one, a second request of the same class is refused.
      add_limit(5'd1);
      add_item(KIND_LAND_REQ, 32'h0000_0010);
      add_item(KIND_LAND_REQ, 32'h0000_0011);
      add_item(KIND_TAKEOFF_REQ, 32'h0000_0012);
      add_item(KIND_TAKEOFF_REQ, 32'h0000_0013);
      add_item(KIND_TICK, 32'h0000_0020);
      add_item(KIND_TICK, 32'h0000_0030);
      add_item(KIND_TICK, 32'h0000_0040);
      // A limit above the depth saturates at the depth. The wait of this
      // landing wraps to all ones.
      add_limit(5'd31);
      add_item(KIND_LAND_REQ, 32'h8000_0000);
      add_item(KIND_TICK, 32'h7FFF_FFFF);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_LIMIT) begin
            set_limit(directed_rows[i].limit);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].want, 0);
         end
      end

      // Random part. Each phase sets a limit, an idle share and a mix of
      // requests and ticks. A request-heavy phase fills the queues into
      // refusals, and a tick-heavy phase drains them into idle ticks. Time
      // stamps mostly follow a running clock, so the waits look realistic.
      // Some stamps are fully random or at the extremes, so that every bit
      // toggles and the waits wrap.
      clock_now = $urandom;
      for (int p = 0; p < PHASES; p++) begin
         lim = (phase_limit[p] > 31) ? LIMIT_W'($urandom_range(31)) :
                                        LIMIT_W'(phase_limit[p]);
         set_limit(lim);
         case (p % 3)
            0:       req_pct = 72;
            1:       req_pct = 30;
            default: req_pct = 50;
         endcase
         land_share = $urandom_range(80, 20);
         n = 0;
         while (n < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
               item.kind = KIND_UNUSED;
            end else if (roll < 3 + req_pct) begin
               item.kind = ($urandom_range(99) < land_share) ? KIND_LAND_REQ
                                                             : KIND_TAKEOFF_REQ;
            end else begin
               item.kind = KIND_TICK;
            end
            clock_now += $urandom_range(40);
            roll = $urandom_range(99);
            if (roll < 8) begin
               item.time_stamp = $urandom;
            end else if (roll < 10) begin
               item.time_stamp = 32'h0000_0000;
            end else if (roll < 12) begin
               item.time_stamp = 32'hFFFF_FFFF;
            end else begin
               item.time_stamp = clock_now;
            end
            send_item(item, 1'b0, '0, pick_gap(phase_idle[p]));
            if (item.kind != KIND_UNUSED) begin
               n++;
            end
         end
      end

      // End of stimulus. Let the last results come in, then flag any
      // expectation that is still waiting.
      start <= 1'b0;
      wait_settled();
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count += pending_results.size();
      end

      $display("Ran %0d transfers and checked %0d results over %0d queue-limit writes.",
               items_accepted, results_checked, limits_written);
      $display("Statuses accepted/refused/landed/took off/idle: %0d/%0d/%0d/%0d/%0d, %s %0d.",
               status_seen[STATUS_ACCEPTED], status_seen[STATUS_REFUSED],
               status_seen[STATUS_LANDED], status_seen[STATUS_TOOK_OFF],
               status_seen[STATUS_IDLE], "deepest queue", deepest_queue);
      if (fail_count == 0) begin
         $display("** two_class_priority_service_queue_core: PASSED **");
      end else begin
         $display("** two_class_priority_service_queue_core: FAILED **");
      end
      $finish;
   end

   // Run limit. The slowest correct run has about two thousand transfers,
   // each with its idle gap and its own execute state, and this limit allows
   // several times the time that such a run takes.
   initial begin
      #5_000_000;
      $display("** two_class_priority_service_queue_core: FAILED **");
      $finish;
   end

endmodule
